/* src/cfr_pkg.sv */
// Shared types and constants for the command frame receiver.
// No dependencies; imported by every module of the block.
package cfr_pkg;

  typedef enum logic [2:0] {
    ST_ANSWERED     = 3'd0,
    ST_UNKNOWN_ITEM = 3'd1,
    ST_BAD_LENGTH   = 3'd2,
    ST_BAD_CHECKSUM = 3'd3,
    ST_BAD_COMMAND  = 3'd4
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER_BYTE  = 2'd0;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd1;
  localparam logic [1:0] REG_READ_CMD     = 2'd2;

  localparam logic [7:0] HEADER_BYTE_RST  = 8'd170;
  localparam logic [7:0] LENGTH_LIMIT_RST = 8'd64;
  localparam logic [7:0] READ_CMD_RST     = 8'd1;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] length_limit;
    logic [7:0] read_command_code;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  command_code;
    logic [14:0] item_id;
    logic [3:0]  sensor_select;
  } result_t;

endpackage

/* src/command_frame_receiver.sv */
// Top level of the command frame receiver: configuration registers, parser, result buffer.
// Depends on cfr_pkg, cfr_parser and cfr_out_buf.
//
// Takes one received byte per clock while in_stall is low and hunts for the header, reads
// the length, the payload and the trailing checksum (0xFF minus the byte sum), then gives
// one status beat per frame end or error. Each result is registered in the output buffer
// before it appears at out_*. A two-entry output buffer sits between the parser and out_*,
// so in_stall rises only when two results wait and the consumer stalls.
// Configuration writes should be made while no frame is in progress.
module command_frame_receiver
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_command_code,
  output logic [14:0] out_item_id,
  output logic [3:0]  out_sensor_select
);

  cfg_t    cfg_r;
  logic    accept;
  logic    res_valid;
  result_t res;
  logic    buf_full;
  result_t out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte       <= HEADER_BYTE_RST;
      cfg_r.length_limit      <= LENGTH_LIMIT_RST;
      cfg_r.read_command_code <= READ_CMD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_BYTE:  cfg_r.header_byte       <= cfg_wdata;
        REG_LENGTH_LIMIT: cfg_r.length_limit      <= cfg_wdata;
        REG_READ_CMD:     cfg_r.read_command_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  cfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  cfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status        = out_data.status;
  assign out_command_code  = out_data.command_code;
  assign out_item_id       = out_data.item_id;
  assign out_sensor_select = out_data.sensor_select;

endmodule

/* src/cfr_parser.sv */
// Frame parser: per-beat state update and frame decode for the receiver.
// Depends on cfr_pkg for the configuration and result types.
module cfr_parser
  import cfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] pay_r [3];
  logic [7:0] pay_nxt [3];

  logic [8:0]  count_inc;
  logic [14:0] item_id;
  logic [7:0]  expect_sum;
  logic        item_known;
  logic [3:0]  item_sel;
  logic        emit;

  // Map the item id onto one of twelve sensor quantities
  function automatic logic [4:0] map_item(input logic [14:0] id);
    logic [14:0] d;
    begin
      d = '0;
      if (id >= 15'h0043 && id <= 15'h0048) begin
        d = id - 15'h0043;
        map_item = {1'b1, d[3:0]};
      end else if (id >= 15'h0053 && id <= 15'h0058) begin
        d = id - 15'h0053 + 15'd6;
        map_item = {1'b1, d[3:0]};
      end else begin
        map_item = 5'd0;
      end
    end
  endfunction

  // byte1 + 100 * byte2, with 100 as 64 + 32 + 4
  assign item_id = {7'd0, pay_r[1]}
                 + ({7'd0, pay_r[2]} << 6)
                 + ({7'd0, pay_r[2]} << 5)
                 + ({7'd0, pay_r[2]} << 2);
  assign expect_sum = 8'hFF - running_sum_r;
  assign {item_known, item_sel} = map_item(item_id);
  assign count_inc = {1'b0, byte_count_r} + 9'd1;

  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    byte_count_nxt   = byte_count_r;
    running_sum_nxt  = running_sum_r;
    pay_nxt          = pay_r;
    emit             = 1'b0;
    res              = '0;
    res.status       = ST_ANSWERED;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.header_byte) begin
          phase_nxt       = PH_LEN;
          byte_count_nxt  = '0;
          running_sum_nxt = '0;
          pay_nxt[0]      = '0;
          pay_nxt[1]      = '0;
          pay_nxt[2]      = '0;
        end
      end
      PH_LEN: begin
        if (rx_byte >= cfg.length_limit) begin
          phase_nxt  = PH_HUNT;
          emit       = 1'b1;
          res.status = ST_BAD_LENGTH;
        end else begin
          frame_length_nxt = rx_byte;
          byte_count_nxt   = '0;
          running_sum_nxt  = '0;
          phase_nxt        = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (byte_count_r < 8'd3) begin
          pay_nxt[byte_count_r[1:0]] = rx_byte;
        end
        running_sum_nxt = running_sum_r + rx_byte;
        byte_count_nxt  = count_inc[7:0];
        if (count_inc >= {1'b0, frame_length_r}) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM: begin
        phase_nxt        = PH_HUNT;
        emit             = 1'b1;
        res.command_code = pay_r[0];
        res.item_id      = item_id;
        priority if (rx_byte != expect_sum) begin
          res.status = ST_BAD_CHECKSUM;
        end else if (pay_r[0] != cfg.read_command_code) begin
          res.status = ST_BAD_COMMAND;
        end else if (!item_known) begin
          res.status = ST_UNKNOWN_ITEM;
        end else begin
          res.status        = ST_ANSWERED;
          res.sensor_select = item_sel;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  assign res_valid = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      frame_length_r <= '0;
      byte_count_r   <= '0;
      running_sum_r  <= '0;
      pay_r[0]       <= '0;
      pay_r[1]       <= '0;
      pay_r[2]       <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      byte_count_r   <= byte_count_nxt;
      running_sum_r  <= running_sum_nxt;
      pay_r          <= pay_nxt;
    end
  end

endmodule

/* src/cfr_out_buf.sv */
// Two-entry result buffer: output register plus a skid register.
// Depends on cfr_pkg for the result type.
module cfr_out_buf
  import cfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop = out_valid_r && !out_stall;

  // push only arrives while the skid register is empty
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = push;
      out_data_nxt  = push ? push_data : out_data_r;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
